[design/kpel_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpel_pkg
// Shared constants and types for the key press edge logger.
// ----------------------------------------------------------------------------
package kpel_pkg;

  localparam int unsigned KEY_COUNT   = 24;
  localparam int unsigned PORT_COUNT  = 3;
  localparam int unsigned PORT_W      = 8;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned LOG_DEPTH   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] NO_KEY_CODE = 5'd31;
  // Port number of the last port visited for one bit position.
  localparam logic [1:0] LAST_PORT = 2'(PORT_COUNT - 1);

  typedef logic [KEY_COUNT-1:0] key_mask_t;

  // Queue fill status, seen by the top level.
  typedef struct packed {
    logic       full;
    logic [1:0] level;
  } queue_stat_t;

  // Walker status, seen by the top level.
  typedef struct packed {
    logic mask_empty;
  } back_stat_t;

endpackage : kpel_pkg
`default_nettype wire

[design/kpel_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpel_front
// Accept scans, find newly pressed keys, queue non-empty press masks.
// ----------------------------------------------------------------------------
module kpel_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     scan_valid_i,
  output logic                    scan_ready_o,
  input  wire  [23:0]             scan_keys_i,
  output logic                    push_valid_o,
  input  wire                     push_ready_i,
  output kpel_pkg::key_mask_t     push_mask_o
);
  import kpel_pkg::*;

  key_mask_t prev_q, prev_d;
  key_mask_t rising;
  logic      accept;

  assign scan_ready_o = push_ready_i;
  assign accept       = scan_valid_i && scan_ready_o;
  assign rising       = scan_keys_i & ~prev_q;

  // Drop scans with no new press: they produce no result.
  assign push_valid_o = accept && (rising != '0);
  assign push_mask_o  = rising;

  always_comb begin
    prev_d = prev_q;
    if (accept) begin
      prev_d = scan_keys_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule : kpel_front
`default_nettype wire

[design/kpel_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpel_queue
// Two-entry queue of press masks between front and back.
// ----------------------------------------------------------------------------
module kpel_queue (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_valid_i,
  output logic                    push_ready_o,
  input  wire  kpel_pkg::key_mask_t push_mask_i,
  output logic                    pop_valid_o,
  input  wire                     pop_ready_i,
  output kpel_pkg::key_mask_t     pop_mask_o,
  output kpel_pkg::queue_stat_t   stat_o
);
  import kpel_pkg::*;

  key_mask_t  mem_q [QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] level_q, level_d;
  logic       do_push, do_pop;

  assign push_ready_o = (level_q != 2'(QUEUE_DEPTH));
  assign pop_valid_o  = (level_q != 2'd0);
  assign pop_mask_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  assign stat_o.full  = !push_ready_o;
  assign stat_o.level = level_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 2'd1;
    end else if (do_pop && !do_push) begin
      level_d = level_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_mask_i;
    end
  end

endmodule : kpel_queue
`default_nettype wire

[design/kpel_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpel_back
// Walk a press mask one key per cycle in interleaved order while the output
// is not stalled, emit indexes, keep the log of recent presses.
// ----------------------------------------------------------------------------
module kpel_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     pop_valid_i,
  output logic                    pop_ready_o,
  input  wire  kpel_pkg::key_mask_t pop_mask_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic [kpel_pkg::IDX_W-1:0] out_index_o,
  output logic                    out_last_o,
  output kpel_pkg::back_stat_t    stat_o
);
  import kpel_pkg::*;

  key_mask_t        mask_q, mask_d;
  logic [1:0]       port_q, port_d;
  logic [2:0]       bit_q, bit_d;
  logic             ovalid_q, ovalid_d;
  logic [IDX_W-1:0] oindex_q, oindex_d;
  logic             olast_q, olast_d;
  logic [IDX_W-1:0] log_q [LOG_DEPTH];

  logic             advance;
  logic             mask_empty;
  logic [IDX_W-1:0] pos;
  key_mask_t        pos_bit;
  key_mask_t        mask_rest;
  logic             hit;

  assign advance    = !ovalid_q || out_ready_i;
  assign mask_empty = (mask_q == '0);
  // Key index is port * 8 + bit.
  assign pos        = {port_q, bit_q};
  assign pos_bit    = KEY_COUNT'(1) << pos;
  assign mask_rest  = mask_q & ~pos_bit;
  assign hit        = advance && !mask_empty && mask_q[pos];

  assign pop_ready_o  = advance && mask_empty;
  assign out_valid_o  = ovalid_q;
  assign out_index_o  = oindex_q;
  assign out_last_o   = olast_q;
  assign stat_o.mask_empty = mask_empty;

  always_comb begin
    mask_d   = mask_q;
    port_d   = port_q;
    bit_d    = bit_q;
    ovalid_d = ovalid_q;
    oindex_d = oindex_q;
    olast_d  = olast_q;
    if (advance) begin
      ovalid_d = 1'b0;
      if (mask_empty) begin
        if (pop_valid_i) begin
          mask_d = pop_mask_i;
          port_d = 2'd0;
          bit_d  = 3'd0;
        end
      end else begin
        if (mask_q[pos]) begin
          ovalid_d = 1'b1;
          oindex_d = pos;
          olast_d  = (mask_rest == '0);
          mask_d   = mask_rest;
        end
        // Step to the next port, then to the next bit position.
        if (port_q == LAST_PORT) begin
          port_d = 2'd0;
          bit_d  = bit_q + 3'd1;
        end else begin
          port_d = port_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      port_q   <= 2'd0;
      bit_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      port_q   <= port_d;
      bit_q    <= bit_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oindex_q <= oindex_d;
    olast_q  <= olast_d;
  end

  // Push each emitted index onto the front of the log, drop the oldest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LOG_DEPTH; k++) begin
        log_q[k] <= NO_KEY_CODE;
      end
    end else if (hit) begin
      for (int k = LOG_DEPTH - 1; k > 0; k--) begin
        log_q[k] <= log_q[k-1];
      end
      log_q[0] <= pos;
    end
  end

endmodule : kpel_back
`default_nettype wire

[design/key_press_edge_logger_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_press_edge_logger_top
// Report keys newly pressed between two 24-key scans.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one transaction is one scan of 24 key bits,
//   three port bytes packed in tdata. A set bit means the key is down.
//   Master channel m_axis_*: one transaction per newly pressed key, the
//   key index in tdata and tlast on the final index of that scan. A scan
//   with no new press yields no transaction at all.
//   Keys are reported in interleaved order: bit i of port A, then B, then
//   C, for i from 0 up, giving indexes i, i+8 and i+16.
// Data flow:
//   The front updates the previous scan in the accept cycle and queues the
//   press mask. The back walker visits one key position per cycle while
//   the output is not stalled, loading each mask and then stepping through
//   the positions up to the last new press of that scan. The two-entry
//   mask queue lets two further scans be taken while the walker is busy.
// Reset:
//   Clear the previous scan to no key down, empty the queue, and fill the
//   recent-press log with the no-key code.
// Output stall:
//   A held result register stops the walker; the queue then fills and
//   s_axis_tready_o drops until the walker frees an entry.
// ----------------------------------------------------------------------------
module key_press_edge_logger_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] port_a_bits, [15:8] port_b_bits, [23:16] port_c_bits
  input  wire  [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [4:0] pressed_index, [7:5] zero
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import kpel_pkg::*;

  logic             push_valid;
  logic             push_ready;
  key_mask_t        push_mask;
  logic             pop_valid;
  logic             pop_ready;
  key_mask_t        pop_mask;
  queue_stat_t      queue_stat;
  back_stat_t       back_stat;
  logic [IDX_W-1:0] out_index;

  // Front: edge detect against the previous scan.
  kpel_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_valid_i (s_axis_tvalid_i),
    .scan_ready_o (s_axis_tready_o),
    .scan_keys_i  (s_axis_tdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_mask_o  (push_mask)
  );

  // Decouple the front from the walker.
  kpel_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_mask_i  (push_mask),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_mask_o   (pop_mask),
    .stat_o       (queue_stat)
  );

  // Back: walk the mask and emit indexes.
  kpel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_mask_i  (pop_mask),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_index_o (out_index),
    .out_last_o  (m_axis_tlast_o),
    .stat_o      (back_stat)
  );

  assign m_axis_tdata_o = {3'b000, out_index};

  // A held result is the last of its scan exactly when no key is left to walk.
  a_last_matches_walker : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == back_stat.mask_empty)
  ) else $error("tlast disagrees with walker state");

  // Never report an index outside the key range.
  a_index_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_index < IDX_W'(KEY_COUNT))
  ) else $error("pressed index out of range");

  // The queue must not be written when full.
  a_no_push_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> !queue_stat.full
  ) else $error("push into full queue");

  // The walker only loads a new mask once the previous one is done.
  a_pop_only_when_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |-> (back_stat.mask_empty && (queue_stat.level != 2'd0))
  ) else $error("mask loaded while walker busy");

endmodule : key_press_edge_logger_top
`default_nettype wire
